FILE: hdl/tdc_hit_word_decoder_macros.svh
// assertion helpers used by the decode module
`ifndef TDC_HIT_WORD_DECODER_MACROS_SVH
`define TDC_HIT_WORD_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TDC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdc decoder check failed");
`define TDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdc decoder check failed");
`else
`define TDC_ASSERT_SAME(label, ante, cons)
`define TDC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/tdc_hwd_pkg.sv
package tdc_hwd_pkg;

	localparam int WORD_W   = 32;
	localparam int EPOCH_W  = 28;
	localparam int COARSE_W = 11;
	localparam int FINE_W   = 10;
	localparam int CHAN_W   = 7;
	localparam int POS_W    = 6;
	localparam int TIME_W   = EPOCH_W + COARSE_W + FINE_W;

	localparam logic [3:0]        EPOCH_TAG    = 4'h6;
	localparam logic [WORD_W-1:0] STOP_WORD    = 32'h0001_5555;
	localparam logic [POS_W-1:0]  POS_MAX      = 6'd63;
	localparam logic [POS_W-1:0]  HEADER_RESET = 6'd13;

	localparam logic STATUS_HIT         = 1'b0;
	localparam logic STATUS_BAD_CHANNEL = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              first_word;
		logic              last_word;
	} in_word_t;

	typedef struct packed {
		logic              status;
		logic [CHAN_W-1:0] channel;
		logic [TIME_W-1:0] time_ticks;
	} result_t;

endpackage

FILE: hdl/tdc_hit_word_decoder.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | word, first_word, last_word
// out     | output    | out_valid / out_ready | status, channel, time_ticks
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (header_words)
//
// one word accepted per cycle while no result is stalled; a hit is registered
// in the input register, then in the result register, around the decode
// arst_n clears epoch, seen map, word position, stop flag and loads header_words 13
// a stalled result holds the pipeline; the input register keeps taking a word
// while a result waits, then stops until out_ready frees the result register
module tdc_hit_word_decoder #(
	parameter int NUM_CHANNELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] word,
	input  logic        first_word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [6:0]  channel,
	output logic [48:0] time_ticks,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	logic [tdc_hwd_pkg::POS_W-1:0] header_words_q;
	tdc_hwd_pkg::in_word_t         in_data;
	tdc_hwd_pkg::in_word_t         data_s1;
	tdc_hwd_pkg::result_t          res_s2;
	logic                          valid_s1;
	logic                          take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_words_q <= tdc_hwd_pkg::HEADER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			header_words_q <= cfg_data;
		end
	end

	assign in_data.word       = word;
	assign in_data.first_word = first_word;
	assign in_data.last_word  = last_word;

	tdc_hwd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.take     (take),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	tdc_hwd_decode #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dec (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.data_s1      (data_s1),
		.take         (take),
		.header_words (header_words_q),
		.res_valid_s2 (out_valid),
		.res_s2       (res_s2),
		.out_ready    (out_ready)
	);

	assign status     = res_s2.status;
	assign channel    = res_s2.channel;
	assign time_ticks = res_s2.time_ticks;

endmodule

FILE: hdl/tdc_hwd_in_stage.sv
module tdc_hwd_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tdc_hwd_pkg::in_word_t in_data,
	input  logic                  take,
	output logic                  valid_s1,
	output tdc_hwd_pkg::in_word_t data_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

endmodule

FILE: hdl/tdc_hwd_decode.sv
`include "tdc_hit_word_decoder_macros.svh"

module tdc_hwd_decode #(
	parameter int NUM_CHANNELS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	input  tdc_hwd_pkg::in_word_t             data_s1,
	output logic                              take,
	input  logic [tdc_hwd_pkg::POS_W-1:0]     header_words,
	output logic                              res_valid_s2,
	output tdc_hwd_pkg::result_t              res_s2,
	input  logic                              out_ready
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [tdc_hwd_pkg::CHAN_W:0] NUM_CH_L = (tdc_hwd_pkg::CHAN_W + 1)'(NUM_CHANNELS);

	logic [tdc_hwd_pkg::EPOCH_W-1:0] epoch_q;
	logic [NUM_CHANNELS-1:0]         seen_q;
	logic [tdc_hwd_pkg::POS_W-1:0]   pos_q;
	logic                            stopped_q;

	logic [tdc_hwd_pkg::EPOCH_W-1:0] epoch_cur, epoch_n;
	logic [NUM_CHANNELS-1:0]         seen_cur, seen_n;
	logic [tdc_hwd_pkg::POS_W-1:0]   pos_cur, pos_n;
	logic                            stop_cur, stop_n;

	logic [tdc_hwd_pkg::WORD_W-1:0]   w;
	logic [tdc_hwd_pkg::CHAN_W-1:0]   ch;
	logic [IDX_W-1:0]                 ch_idx;
	logic [tdc_hwd_pkg::COARSE_W-1:0] coarse;
	logic [tdc_hwd_pkg::FINE_W-1:0]   fine;
	logic                             ch_ok;
	logic                             produce;
	logic                             is_error;
	tdc_hwd_pkg::result_t             res_n;

	assign take = valid_s1 && (!res_valid_s2 || out_ready);

	assign w      = data_s1.word;
	assign ch     = w[28:22];
	assign ch_idx = ch[IDX_W-1:0];
	assign coarse = w[10:0];
	assign fine   = w[21:12];
	assign ch_ok  = {1'b0, ch} < NUM_CH_L;

	always_comb begin
		epoch_cur = data_s1.first_word ? '0 : epoch_q;
		seen_cur  = data_s1.first_word ? '0 : seen_q;
		pos_cur   = data_s1.first_word ? '0 : pos_q;
		stop_cur  = data_s1.first_word ? 1'b0 : stopped_q;
		epoch_n   = epoch_cur;
		seen_n    = seen_cur;
		pos_n     = pos_cur;
		stop_n    = stop_cur;
		produce   = 1'b0;
		is_error  = 1'b0;
		res_n.status     = tdc_hwd_pkg::STATUS_HIT;
		res_n.channel    = ch;
		res_n.time_ticks = {epoch_cur, coarse, fine};
		if (!stop_cur) begin
			if (pos_cur < tdc_hwd_pkg::POS_MAX) begin
				pos_n = pos_cur + 1'b1;
			end
			if (pos_cur >= header_words) begin
				if (w[31:28] == tdc_hwd_pkg::EPOCH_TAG) begin
					epoch_n = w[tdc_hwd_pkg::EPOCH_W-1:0];
				end else if (w[31]) begin
					if (!ch_ok) begin
						produce  = 1'b1;
						is_error = 1'b1;
						stop_n   = 1'b1;
						res_n.status     = tdc_hwd_pkg::STATUS_BAD_CHANNEL;
						res_n.time_ticks = '0;
					end else if (!seen_cur[ch_idx]) begin
						produce        = 1'b1;
						seen_n[ch_idx] = 1'b1;
					end
				end else if (w == tdc_hwd_pkg::STOP_WORD) begin
					stop_n = 1'b1;
				end
			end
		end
		if (data_s1.last_word) begin
			stop_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= '0;
			seen_q       <= '0;
			pos_q        <= '0;
			stopped_q    <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else if (take) begin
			epoch_q      <= epoch_n;
			seen_q       <= seen_n;
			pos_q        <= pos_n;
			stopped_q    <= stop_n;
			res_valid_s2 <= produce;
		end else if (out_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produce) begin
			res_s2 <= res_n;
		end
	end

	`TDC_ASSERT_SAME(a_err_zero_time, res_valid_s2 && res_s2.status, res_s2.time_ticks == '0)
	`TDC_ASSERT_NEXT(a_err_stops, take && is_error, stopped_q)
	`TDC_ASSERT_NEXT(a_hit_marks_seen, take && produce && !is_error, seen_q[$past(ch_idx)])
	`TDC_ASSERT_NEXT(a_last_stops, take && data_s1.last_word, stopped_q)

endmodule

FILE: dv/tdc_hit_word_decoder_checker.sv
module tdc_hit_word_decoder_checker #(
	parameter int NUM_CHANNELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] word,
	input  logic        first_word,
	input  logic        last_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        status,
	input  logic [6:0]  channel,
	input  logic [48:0] time_ticks,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [tdc_hwd_pkg::POS_W-1:0]   hdr_len;
	logic [tdc_hwd_pkg::EPOCH_W-1:0] cur_epoch;
	logic [NUM_CHANNELS-1:0]         seen_map;
	logic [tdc_hwd_pkg::POS_W-1:0]   pos;
	logic                            halted;
	tdc_hwd_pkg::result_t            predicted_hits[$];

	function automatic void clear_subevent();
		cur_epoch = '0;
		seen_map = '0;
		pos = '0;
		halted = 1'b0;
	endfunction

	function automatic bit decode_word(input logic [tdc_hwd_pkg::WORD_W-1:0] w,
		input logic fw, input logic lw, output tdc_hwd_pkg::result_t hit);
		logic [tdc_hwd_pkg::CHAN_W-1:0] ch;
		bit got;
		got = 1'b0;
		hit = '0;
		ch = w[28:22];
		if (fw)
			clear_subevent();
		if (!halted) begin
			if (pos >= hdr_len) begin
				if (w[31:28] == tdc_hwd_pkg::EPOCH_TAG) begin
					cur_epoch = w[tdc_hwd_pkg::EPOCH_W-1:0];
				end else if (w[31]) begin
					if (ch >= NUM_CHANNELS) begin
						hit.status = tdc_hwd_pkg::STATUS_BAD_CHANNEL;
						hit.channel = ch;
						hit.time_ticks = '0;
						got = 1'b1;
						halted = 1'b1;
					end else if (!seen_map[ch[IDX_W-1:0]]) begin
						seen_map[ch[IDX_W-1:0]] = 1'b1;
						hit.status = tdc_hwd_pkg::STATUS_HIT;
						hit.channel = ch;
						hit.time_ticks = {cur_epoch, w[10:0], w[21:12]};
						got = 1'b1;
					end
				end else if (w == tdc_hwd_pkg::STOP_WORD) begin
					halted = 1'b1;
				end
			end
			if (pos != tdc_hwd_pkg::POS_MAX)
				pos = pos + 1'b1;
		end
		if (lw)
			halted = 1'b1;
		return got;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tdc_hwd_pkg::result_t hit;
		tdc_hwd_pkg::result_t want;
		if (!arst_n) begin
			hdr_len = tdc_hwd_pkg::HEADER_RESET;
			clear_subevent();
			predicted_hits.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				hdr_len = cfg_data;
			if (in_valid && in_ready) begin
				if (decode_word(word, first_word, last_word, hit))
					predicted_hits = {predicted_hits, hit};
			end
			if (out_valid && out_ready) begin
				if (predicted_hits.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d channel %0d time %0h",
							status, channel, time_ticks);
				end else begin
					want = predicted_hits.pop_front();
					if (status !== want.status || channel !== want.channel ||
						time_ticks !== want.time_ticks) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %0d %0d %0h, got %0d %0d %0h",
								want.status, want.channel, want.time_ticks,
								status, channel, time_ticks);
					end
				end
			end
		end
		pending = predicted_hits.size();
	end

endmodule

FILE: dv/tdc_hit_word_decoder_tb.sv
module tdc_hit_word_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CHANNELS = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_WORDS = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] word = '0;
	logic        first_word = 1'b0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        status;
	logic [6:0]  channel;
	logic [48:0] time_ticks;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;

	int fail_count;
	int pending;
	int sent_words = 0;
	int quiet_cycles = 0;
	bit idling = 1'b1;
	bit hold_req = 1'b0;
	logic [5:0] hdr_cur = tdc_hwd_pkg::HEADER_RESET;

	tdc_hit_word_decoder #(.NUM_CHANNELS(NUM_CHANNELS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.word(word), .first_word(first_word), .last_word(last_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .channel(channel), .time_ticks(time_ticks),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	tdc_hit_word_decoder_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.word(word), .first_word(first_word), .last_word(last_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .channel(channel), .time_ticks(time_ticks),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tdc_hit_word_decoder_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random bursts of backpressure, one long hold-off on request
	always begin
		@(negedge clk);
		if (hold_req) begin
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_req = 1'b0;
			out_ready <= 1'b1;
		end else if (idling && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [31:0] time_word(input logic [6:0] ch, input logic [9:0] fine,
		input logic [10:0] coarse);
		return {1'b1, 2'($urandom()), ch, fine, 1'($urandom()), coarse};
	endfunction

	function automatic logic [31:0] epoch_word(input logic [27:0] e);
		return {tdc_hwd_pkg::EPOCH_TAG, e};
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic put_word(input logic [31:0] w, input logic fw, input logic lw);
		if (idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		word <= w;
		first_word <= fw;
		last_word <= lw;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent_words++;
	endtask

	task automatic set_header(input logic [5:0] h);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// words with no result may still be in flight
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= h;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		hdr_cur = h;
	endtask

	task automatic send_subevent(input int body_len);
		int total;
		int pick;
		int ch_top;
		bit open_start;
		bit open_end;
		logic [31:0] w;
		total = hdr_cur + body_len;
		open_start = ($urandom_range(0, 19) == 0);
		open_end = ($urandom_range(0, 9) == 0);
		ch_top = ($urandom_range(0, 3) == 0) ? 7 : NUM_CHANNELS - 1;
		for (int i = 0; i < total; i++) begin
			pick = $urandom_range(0, 99);
			if (i < hdr_cur)
				w = $urandom();
			else if (pick < 15)
				w = epoch_word(28'($urandom()));
			else if (pick < 78)
				w = time_word(7'($urandom_range(0, ch_top)), 10'($urandom()), 11'($urandom()));
			else if (pick < 80)
				w = time_word(7'($urandom_range(NUM_CHANNELS, 127)), 10'($urandom()),
					11'($urandom()));
			else if (pick < 82)
				w = tdc_hwd_pkg::STOP_WORD;
			else
				w = {1'b0, 31'($urandom())};
			put_word(w, i == 0 && !open_start, i == total - 1 && !open_end);
		end
		// stray words between subevents
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) put_word($urandom(), 1'b0, 1'b0);
	endtask

	initial begin
		logic [5:0] h;
		int start;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// out of reset: acts as an open subevent with the reset header length
		for (int i = 0; i < tdc_hwd_pkg::HEADER_RESET; i++)
			put_word(time_word(7'(i), 10'($urandom()), 11'($urandom())), 1'b0, 1'b0);
		put_word(time_word(7'd9, 10'h155, 11'h2aa), 1'b0, 1'b0);
		put_word(32'h0000_0000, 1'b0, 1'b1);

		set_header(6'd0);
		put_word({1'b1, 2'b00, 7'd0, 10'h000, 1'b0, 11'h000}, 1'b1, 1'b0);
		put_word(epoch_word(28'hfff_ffff), 1'b0, 1'b0);
		put_word({1'b1, 2'b11, 7'd63, 10'h3ff, 1'b1, 11'h7ff}, 1'b0, 1'b0);
		put_word(time_word(7'd63, 10'h000, 11'h000), 1'b0, 1'b0);
		put_word(epoch_word(28'h000_0000), 1'b0, 1'b0);
		put_word(time_word(7'd1, 10'h3ff, 11'h000), 1'b0, 1'b0);
		put_word(32'h7fff_ffff, 1'b0, 1'b0);
		put_word(32'h0001_5554, 1'b0, 1'b0);
		put_word(tdc_hwd_pkg::STOP_WORD, 1'b0, 1'b0);
		put_word(time_word(7'd2, 10'h001, 11'h001), 1'b0, 1'b1);
		put_word(time_word(7'd3, 10'h002, 11'h002), 1'b0, 1'b0);
		put_word(time_word(7'd64, 10'h123, 11'h456), 1'b1, 1'b0);
		put_word(time_word(7'd5, 10'h005, 11'h005), 1'b0, 1'b1);
		put_word(32'hffff_ffff, 1'b1, 1'b1);
		put_word(time_word(7'd10, 10'h2aa, 11'h555), 1'b1, 1'b1);
		put_word(epoch_word(28'h5a5_a5a5), 1'b1, 1'b0);
		put_word(time_word(7'd7, 10'h0f0, 11'h70f), 1'b0, 1'b0);
		put_word(time_word(7'd7, 10'h30f, 11'h0f0), 1'b1, 1'b0);
		put_word(time_word(7'd63, 10'h111, 11'h222), 1'b0, 1'b1);

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: h = 6'd0;
				1: h = tdc_hwd_pkg::HEADER_RESET;
				2: h = tdc_hwd_pkg::POS_MAX;
				3: h = 6'd1;
				4: h = 6'($urandom_range(2, 20));
				5: h = 6'd62;
				default: h = 6'd0;
			endcase
			set_header(h);
			if (p == 0)
				hold_req = 1'b1;
			if (p == 6)
				idling = 1'b0;
			start = sent_words;
			while (sent_words - start < PHASE_WORDS)
				send_subevent(($urandom_range(0, 9) == 0) ? $urandom_range(50, 90) :
					$urandom_range(1, 30));
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tdc_hit_word_decoder_tb: done, clean");
		else
			$display("tdc_hit_word_decoder_tb: done, errors");
		$finish;
	end

endmodule
